/* src/lsu_pkg.sv */
// Shared opcodes, access decode and constants for the load/store unit.
package lsu_pkg;

   localparam int MEM_BYTES_DEF = 1024;
   localparam int LANES         = 4;

   localparam logic [5:0] OP_LW  = 6'h23;
   localparam logic [5:0] OP_LH  = 6'h21;
   localparam logic [5:0] OP_LHU = 6'h25;
   localparam logic [5:0] OP_LB  = 6'h20;
   localparam logic [5:0] OP_LBU = 6'h24;
   localparam logic [5:0] OP_SW  = 6'h2B;
   localparam logic [5:0] OP_SH  = 6'h29;
   localparam logic [5:0] OP_SB  = 6'h28;

   localparam logic [2:0] NB_NONE = 3'd0;
   localparam logic [2:0] NB_BYTE = 3'd1;
   localparam logic [2:0] NB_HALF = 3'd2;
   localparam logic [2:0] NB_WORD = 3'd4;

   localparam logic [31:0] SEXT_HALF = 32'hffff0000;
   localparam logic [31:0] SEXT_BYTE = 32'hffffff00;

   typedef struct packed {
      logic       is_load;
      logic       is_store;
      logic       sign;
      logic [2:0] nbytes;
   } access_type;

   function automatic access_type lsu_decode(input logic [5:0] op);
      access_type a;
      a = '{is_load: 1'b0, is_store: 1'b0, sign: 1'b0, nbytes: NB_NONE};
      unique case (op)
         OP_LW:   a = '{is_load: 1'b1, is_store: 1'b0, sign: 1'b0, nbytes: NB_WORD};
         OP_LH:   a = '{is_load: 1'b1, is_store: 1'b0, sign: 1'b1, nbytes: NB_HALF};
         OP_LHU:  a = '{is_load: 1'b1, is_store: 1'b0, sign: 1'b0, nbytes: NB_HALF};
         OP_LB:   a = '{is_load: 1'b1, is_store: 1'b0, sign: 1'b1, nbytes: NB_BYTE};
         OP_LBU:  a = '{is_load: 1'b1, is_store: 1'b0, sign: 1'b0, nbytes: NB_BYTE};
         OP_SW:   a = '{is_load: 1'b0, is_store: 1'b1, sign: 1'b0, nbytes: NB_WORD};
         OP_SH:   a = '{is_load: 1'b0, is_store: 1'b1, sign: 1'b0, nbytes: NB_HALF};
         OP_SB:   a = '{is_load: 1'b0, is_store: 1'b1, sign: 1'b0, nbytes: NB_BYTE};
         default: a = '{is_load: 1'b0, is_store: 1'b0, sign: 1'b0, nbytes: NB_NONE};
      endcase
      return a;
   endfunction

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOAD  = 3'b100
   } state_type;

endpackage

/* src/lsu_req_if.sv */
// Request channel of the load/store unit.
interface lsu_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  req_type;
   logic [31:0] address;
   logic [31:0] write_data;

   modport source (output valid, output req_type, output address, output write_data,
                   input ready);
   modport sink   (input valid, input req_type, input address, input write_data,
                   output ready);
endinterface

/* src/lsu_rsp_if.sv */
// Response channel of the load/store unit.
interface lsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] load_data;
   logic        misaligned;
   logic        out_of_range;

   modport source (output valid, output load_data, output misaligned, output out_of_range,
                   input ready);
   modport sink   (input valid, input load_data, input misaligned, input out_of_range,
                   output ready);
endinterface

/* src/load_store_unit.sv */
// Load/store unit: memory stage with big-endian byte-addressed data memory.
//
//   port  dir  word fields                               accepted when
//   req   in   req_type, address, write_data            req.valid && req.ready
//   rsp   out  load_data, misaligned, out_of_range      rsp.valid && rsp.ready
//
// Stores, faulted accesses and other opcodes are answered in the cycle after they
// are taken; a load passes the registered read of the data memory, then ST_LOAD.
// After reset a clearing pass zeroes all (MEM_BYTES+3)/4 rows of the memory,
// one 4-byte row per cycle, with req.ready low.
// The response register holds its word under stall; a new request is taken
// in the cycle the pending response leaves.
module load_store_unit #(
   parameter int MEM_BYTES = lsu_pkg::MEM_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lsu_req_if.sink   req,
   lsu_rsp_if.source rsp
);
   import lsu_pkg::*;

   localparam int ROWS  = (MEM_BYTES + LANES - 1) / LANES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   state_type             state_ff, state_in;
   logic [ROW_W-1:0]      clr_row_ff, clr_row_in;
   logic [31:0]           load_reg_ff, load_reg_in;
   logic [2:0]            ld_nbytes_ff, ld_nbytes_in;
   logic                  ld_sign_ff, ld_sign_in;
   logic [1:0]            ld_off_ff, ld_off_in;
   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_data_ff, out_data_in;
   logic                  out_mis_ff, out_mis_in;
   logic                  out_oor_ff, out_oor_in;

   access_type            acc;
   logic                  accept;
   logic                  mis;
   logic                  oor;
   logic                  fault;
   logic                  store_wr;
   logic                  load_rd;
   logic [ROW_W-1:0]      req_row;
   logic [LANES-1:0]      st_be;
   logic [31:0]           st_word;
   logic                  ram_wr_en;
   logic [LANES-1:0]      ram_wr_be;
   logic [ROW_W-1:0]      ram_wr_row;
   logic [LANES-1:0][7:0] ram_wr_data;
   logic [LANES-1:0][7:0] ram_rd_data;
   logic [31:0]           rd_word;
   logic [15:0]           rd_half;
   logic [7:0]            rd_byte;
   logic [31:0]           ld_value;

   assign acc     = lsu_decode(req.req_type);
   assign req_row = req.address[ROW_W+1:2];

   always_comb begin
      mis = 1'b0;
      unique case (acc.nbytes)
         NB_WORD: mis = req.address[1:0] != 2'b00;
         NB_HALF: mis = req.address[0];
         default: mis = 1'b0;
      endcase
   end

   assign oor   = (acc.nbytes != NB_NONE) &&
                  (({1'b0, req.address} + 33'(acc.nbytes)) > 33'(MEM_BYTES));
   assign fault = mis || oor;

   assign req.ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign store_wr  = accept && acc.is_store && !fault;
   assign load_rd   = accept && acc.is_load && !fault;

   always_comb begin
      st_be   = 4'b1000 >> req.address[1:0];
      st_word = {4{req.write_data[7:0]}};
      unique case (acc.nbytes)
         NB_WORD: begin
            st_be   = 4'b1111;
            st_word = req.write_data;
         end
         NB_HALF: begin
            st_be   = req.address[1] ? 4'b0011 : 4'b1100;
            st_word = {2{req.write_data[15:0]}};
         end
         default: begin
            st_be   = 4'b1000 >> req.address[1:0];
            st_word = {4{req.write_data[7:0]}};
         end
      endcase
   end

   assign ram_wr_en   = (state_ff == ST_CLEAR) || store_wr;
   assign ram_wr_be   = (state_ff == ST_CLEAR) ? {LANES{1'b1}} : st_be;
   assign ram_wr_row  = (state_ff == ST_CLEAR) ? clr_row_ff : req_row;
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0 : st_word;

   lsu_ram #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_be   (ram_wr_be),
      .wr_row  (ram_wr_row),
      .wr_data (ram_wr_data),
      .rd_en   (load_rd),
      .rd_row  (req_row),
      .rd_data (ram_rd_data)
   );

   assign rd_word = ram_rd_data;
   assign rd_half = ld_off_ff[1] ? rd_word[15:0] : rd_word[31:16];

   always_comb begin
      rd_byte = rd_word[31:24];
      unique case (ld_off_ff)
         2'd0:    rd_byte = rd_word[31:24];
         2'd1:    rd_byte = rd_word[23:16];
         2'd2:    rd_byte = rd_word[15:8];
         default: rd_byte = rd_word[7:0];
      endcase
   end

   always_comb begin
      ld_value = rd_word;
      unique case (ld_nbytes_ff)
         NB_WORD: ld_value = rd_word;
         NB_HALF: ld_value = (ld_sign_ff && rd_half[15]) ? (SEXT_HALF | {16'b0, rd_half})
                                                         : {16'b0, rd_half};
         default: ld_value = (ld_sign_ff && rd_byte[7]) ? (SEXT_BYTE | {24'b0, rd_byte})
                                                        : {24'b0, rd_byte};
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      load_reg_in  = load_reg_ff;
      ld_nbytes_in = ld_nbytes_ff;
      ld_sign_in   = ld_sign_ff;
      ld_off_in    = ld_off_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_data_in  = out_data_ff;
      out_mis_in   = out_mis_ff;
      out_oor_in   = out_oor_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            load_reg_in  = ld_value;
            out_valid_in = 1'b1;
            out_data_in  = ld_value;
            out_mis_in   = 1'b0;
            out_oor_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            if (load_rd) begin
               ld_nbytes_in = acc.nbytes;
               ld_sign_in   = acc.sign;
               ld_off_in    = req.address[1:0];
               state_in     = ST_LOAD;
            end else if (accept) begin
               out_valid_in = 1'b1;
               out_data_in  = load_reg_ff;
               out_mis_in   = mis;
               out_oor_in   = oor;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         load_reg_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         load_reg_ff  <= load_reg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_nbytes_ff <= ld_nbytes_in;
      ld_sign_ff   <= ld_sign_in;
      ld_off_ff    <= ld_off_in;
      out_data_ff  <= out_data_in;
      out_mis_ff   <= out_mis_in;
      out_oor_ff   <= out_oor_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.load_data    = out_data_ff;
   assign rsp.misaligned   = out_mis_ff;
   assign rsp.out_of_range = out_oor_ff;

   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> out_valid_ff && (out_data_ff == load_reg_ff))
      else $error("load result not delivered after read");

   a_load_reg_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |=> $stable(load_reg_ff))
      else $error("load register changed outside load completion");

   a_clean_load_rd: assert property (@(posedge clock) disable iff (reset)
      load_rd |=> (state_ff == ST_LOAD) && !out_valid_ff)
      else $error("load read did not enter completion with free response register");

   a_no_store_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !store_wr && !load_rd)
      else $error("access taken during memory clearing");

endmodule

/* src/lsu_ram.sv */
// Byte-lane data memory, one write and one registered read port.
module lsu_ram #(
   parameter int ROWS  = lsu_pkg::MEM_BYTES_DEF / lsu_pkg::LANES,
   parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [lsu_pkg::LANES-1:0]         wr_be,
   input  logic [ROW_W-1:0]                  wr_row,
   input  logic [lsu_pkg::LANES-1:0][7:0]    wr_data,
   input  logic                              rd_en,
   input  logic [ROW_W-1:0]                  rd_row,
   output logic [lsu_pkg::LANES-1:0][7:0]    rd_data
);
   import lsu_pkg::*;

   logic [LANES-1:0][7:0] ram_ff [ROWS];
   logic [LANES-1:0][7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < LANES; i++) begin
            if (wr_be[i]) begin
               ram_ff[wr_row][i] <= wr_data[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/lsu_access_checker.sv */
// Watches the load/store unit channels, predicts every response and compares it.
`timescale 1ns / 1ps
module lsu_access_checker #(
   parameter int MEM_BYTES = lsu_pkg::MEM_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   lsu_req_if   req,
   lsu_rsp_if   rsp,
   output int   fail_count,
   output int   pending
);
   import lsu_pkg::*;

   typedef struct packed {
      logic [31:0] load_data;
      logic        misaligned;
      logic        out_of_range;
   } lsu_result_type;

   logic [7:0]     mem_image [MEM_BYTES];
   logic [31:0]    load_reg;
   lsu_result_type access_results [$];
   int             err_count = 0;

   assign fail_count = err_count;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic lsu_result_type execute_access(input logic [5:0] op,
                                                    input logic [31:0] addr,
                                                    input logic [31:0] wdata);
      lsu_result_type res;
      int             nbytes;
      logic           is_store;
      logic [31:0]    v;
      logic [32:0]    span_end;
      nbytes   = 0;
      is_store = 1'b0;
      res      = '0;
      case (op)
         OP_LW:        nbytes = 4;
         OP_LH, OP_LHU: nbytes = 2;
         OP_LB, OP_LBU: nbytes = 1;
         OP_SW: begin
            nbytes   = 4;
            is_store = 1'b1;
         end
         OP_SH: begin
            nbytes   = 2;
            is_store = 1'b1;
         end
         OP_SB: begin
            nbytes   = 1;
            is_store = 1'b1;
         end
         default: nbytes = 0;
      endcase
      if (nbytes != 0) begin
         res.misaligned   = (nbytes == 4 && addr[1:0] != 2'b00) || (nbytes == 2 && addr[0]);
         span_end         = {1'b0, addr} + 33'(nbytes);
         res.out_of_range = span_end > 33'(MEM_BYTES);
         if (!res.misaligned && !res.out_of_range) begin
            if (is_store) begin
               for (int i = 0; i < nbytes; i++) begin
                  mem_image[int'(addr) + i] = 8'(wdata >> (8 * (nbytes - 1 - i)));
               end
            end else begin
               v = '0;
               for (int i = 0; i < nbytes; i++) begin
                  v = {v[23:0], mem_image[int'(addr) + i]};
               end
               if (op == OP_LH && v[15]) begin
                  v = v | SEXT_HALF;
               end else if (op == OP_LB && v[7]) begin
                  v = v | SEXT_BYTE;
               end
               load_reg = v;
            end
         end
      end
      res.load_data = load_reg;
      return res;
   endfunction

   always @(posedge clock) begin
      lsu_result_type want;
      if (reset) begin
         for (int i = 0; i < MEM_BYTES; i++) begin
            mem_image[i] = '0;
         end
         load_reg = '0;
         access_results.delete();
      end else begin
         if (req.valid && req.ready) begin
            access_results.push_back(execute_access(req.req_type, req.address, req.write_data));
         end
         if (rsp.valid && rsp.ready) begin
            if (access_results.size() == 0) begin
               report_mismatch($sformatf("response word with none awaited, load_data %h",
                                         rsp.load_data));
            end else begin
               want = access_results.pop_front();
               if (rsp.load_data !== want.load_data) begin
                  report_mismatch($sformatf("load_data %h, want %h",
                                            rsp.load_data, want.load_data));
               end
               if (rsp.misaligned !== want.misaligned) begin
                  report_mismatch($sformatf("misaligned %b, want %b",
                                            rsp.misaligned, want.misaligned));
               end
               if (rsp.out_of_range !== want.out_of_range) begin
                  report_mismatch($sformatf("out_of_range %b, want %b",
                                            rsp.out_of_range, want.out_of_range));
               end
            end
         end
      end
      pending <= access_results.size();
   end

endmodule

/* verif/testbench.sv */
// Stimulus, idling and verdict for the load/store unit testbench.
`timescale 1ns / 1ps
module testbench;
   import lsu_pkg::*;

   localparam int MEM_BYTES   = MEM_BYTES_DEF;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsu_req_if req ();
   lsu_rsp_if rsp ();

   int fail_count;
   int pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   bit squeeze   = 1'b0;
   int held      = 0;
   int quiet     = 0;

   logic [5:0] access_ops [8] = '{OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB};

   always #6 clock = ~clock;

   load_store_unit #(.MEM_BYTES(MEM_BYTES)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   lsu_access_checker #(.MEM_BYTES(MEM_BYTES)) access_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // hold off the response side once for a long stretch
   always @(posedge clock) begin
      if (squeeze && held < HOLD_CYCLES) begin
         rsp.ready <= 1'b0;
         held      <= held + 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic offer_access(input logic [5:0] op, input logic [31:0] addr,
                               input logic [31:0] wdata);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.req_type   <= op;
      req.address    <= addr;
      req.write_data <= wdata;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic random_access();
      logic [5:0]  op;
      logic [31:0] addr;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 85) begin
         op = access_ops[$urandom_range(7)];
      end else begin
         op = 6'($urandom_range(63));
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
         addr = $urandom_range(63);
      end else if (pick < 65) begin
         addr = MEM_BYTES - 64 + $urandom_range(63);
      end else if (pick < 85) begin
         addr = $urandom_range(MEM_BYTES - 1);
      end else begin
         addr = $urandom;
      end
      if ($urandom_range(99) < 80) begin
         case (op)
            OP_LW, OP_SW:          addr[1:0] = 2'b00;
            OP_LH, OP_LHU, OP_SH:  addr[0]   = 1'b0;
            default:               addr      = addr;
         endcase
      end
      offer_access(op, addr, $urandom);
   endtask

   initial begin
      req.valid      = 1'b0;
      req.req_type   = '0;
      req.address    = '0;
      req.write_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      offer_access(OP_SW,  32'd0, 32'h11223344);
      offer_access(OP_LW,  32'd0, 32'h0);
      offer_access(OP_LBU, 32'd0, 32'h0);
      offer_access(OP_SW,  32'd4, 32'h80FF7F01);
      offer_access(OP_LH,  32'd4, 32'h0);
      offer_access(OP_LHU, 32'd4, 32'h0);
      offer_access(OP_LB,  32'd4, 32'h0);
      offer_access(OP_LBU, 32'd4, 32'h0);
      offer_access(OP_LH,  32'd6, 32'h0);
      offer_access(OP_LB,  32'd6, 32'h0);
      offer_access(OP_SH,  32'd8, 32'hFFFFABCD);
      offer_access(OP_SB,  32'd11, 32'hFFFFFF5A);
      offer_access(OP_LW,  32'd8, 32'h0);
      offer_access(OP_LW,  32'd2, 32'h0);
      offer_access(OP_SW,  32'd1, 32'hDEADBEEF);
      offer_access(OP_LH,  32'd5, 32'h0);
      offer_access(OP_LB,  32'd5, 32'h0);
      offer_access(OP_SW,  MEM_BYTES - 4, 32'hFFFFFFFF);
      offer_access(OP_LW,  MEM_BYTES - 4, 32'h0);
      offer_access(OP_SB,  MEM_BYTES, 32'h12);
      offer_access(OP_LW,  MEM_BYTES - 2, 32'h0);
      offer_access(OP_LH,  32'hFFFFFFFE, 32'h0);
      offer_access(OP_SW,  32'hFFFFFFFC, 32'h0);
      offer_access(6'h3F,  32'd0, 32'hFFFFFFFF);
      offer_access(6'h00,  32'd0, 32'h0);

      repeat (PHASE_WORDS) random_access();
      idle_pct = 78;
      repeat (PHASE_WORDS) random_access();
      idle_pct  = 0;
      stall_pct = 78;
      repeat (PHASE_WORDS) random_access();
      idle_pct  = 11;
      stall_pct = 11;
      repeat (PHASE_WORDS) random_access();
      idle_pct  = 0;
      stall_pct = 0;
      squeeze  <= 1'b1;
      repeat (125) random_access();
      req.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/lsu_pkg.sv
src/lsu_req_if.sv
src/lsu_rsp_if.sv
src/lsu_ram.sv
src/load_store_unit.sv
verif/lsu_access_checker.sv
verif/testbench.sv
